[rtl/ltk_pkg.sv]
// shared types and constants of the line language tokenizer
// token kinds, status codes and the result beat layout; no dependencies
package ltk_pkg;

   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 4;
   localparam int TEXT_W   = 64;
   localparam int LEN_W    = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 16;

   localparam logic [KIND_W-1:0] KIND_STATUS = 4'd0;
   localparam logic [KIND_W-1:0] KIND_NAME   = 4'd1;
   localparam logic [KIND_W-1:0] KIND_HASH   = 4'd2;
   localparam logic [KIND_W-1:0] KIND_DOLLAR = 4'd3;
   localparam logic [KIND_W-1:0] KIND_EOL    = 4'd4;
   localparam logic [KIND_W-1:0] KIND_EQUALS = 4'd5;
   localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd6;
   localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd7;
   localparam logic [KIND_W-1:0] KIND_COMMA  = 4'd8;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CHAR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]   token_kind;
      logic [BYTE_W-1:0]   token_char;
      logic [TEXT_W-1:0]   name_text;
      logic [LEN_W-1:0]    name_length;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  token_count;
      logic                last;
   } rsp_type;

endpackage

[rtl/ltk_req_if.sv]
// input channel of the tokenizer: one source byte or end of input per beat
// depends on ltk_pkg
interface ltk_req_if import ltk_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

[rtl/ltk_rsp_if.sv]
// result channel of the tokenizer: one token or status beat per transfer
// depends on ltk_pkg
interface ltk_rsp_if import ltk_pkg::*;;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   token_kind;
   logic [BYTE_W-1:0]   token_char;
   logic [TEXT_W-1:0]   name_text;
   logic [LEN_W-1:0]    name_length;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  token_count;
   logic                last;

   modport source (output valid, output token_kind, output token_char, output name_text,
                   output name_length, output status, output token_count, output last,
                   input ready);
   modport sink   (input valid, input token_kind, input token_char, input name_text,
                   input name_length, input status, input token_count, input last,
                   output ready);
endinterface

[rtl/line_language_tokenizer_unit.sv]
// line language tokenizer: byte-serial lexer with a four-beat result queue
// depends on ltk_pkg, ltk_req_if and ltk_rsp_if
// result beats are registered in the result queue when their input beat is taken
// throughput: one input beat per cycle while the queue has room for two beats;
//   a beat giving two tokens puts two beats on the result side, absorbed by the four-entry result queue
// reset: synchronous, clears lexer state, token count and the result queue
module line_language_tokenizer_unit import ltk_pkg::*; #(
   parameter int NAME_BYTES = 8
) (
   input  logic       clock,
   input  logic       reset,
   ltk_req_if.sink    req_ch,
   ltk_rsp_if.source  rsp_ch
);

   localparam int FILL_W  = $clog2(NAME_BYTES + 1);
   localparam int Q_DEPTH = 4;
   localparam int PTR_W   = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_NAME,
      MODE_WANT_LF
   } mode_type;

   mode_type            mode_ff, mode_in;
   logic [BYTE_W-1:0]   buf_ff [NAME_BYTES];
   logic [BYTE_W-1:0]   buf_in [NAME_BYTES];
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [STATUS_W-1:0] err_ff, err_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;

   rsp_type             queue_ff [Q_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   qcnt_ff, qcnt_in;

   rsp_type             res0, res1;
   logic [1:0]          n_res;
   logic                cnt_clear;
   logic                accept, pop;
   logic [COUNT_W:0]    cnt_sum;

   function automatic logic is_letter(input logic [BYTE_W-1:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
             (c >= 8'hC0 && c <= 8'hD6) || (c >= 8'hD8 && c <= 8'hF6) ||
             (c >= 8'hF8);
   endfunction

   function automatic logic [KIND_W-1:0] punct_kind(input logic [BYTE_W-1:0] c);
      logic [KIND_W-1:0] k;
      unique case (c)
         "=":     k = KIND_EQUALS;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         ",":     k = KIND_COMMA;
         default: k = KIND_STATUS;
      endcase
      return k;
   endfunction

   assign accept = req_ch.valid && req_ch.ready;
   assign pop    = rsp_ch.valid && rsp_ch.ready;

   // room for two beats means any item can be taken
   assign req_ch.ready = (qcnt_ff <= QCNT_W'(Q_DEPTH - 2));

   always_comb begin
      logic [BYTE_W-1:0] c;
      logic [TEXT_W-1:0] text;
      rsp_type           name_res;
      rsp_type           char_res;
      logic              name_char;

      c         = req_ch.in_byte;
      mode_in   = mode_ff;
      buf_in    = buf_ff;
      fill_in   = fill_ff;
      err_in    = err_ff;
      cnt_clear = 1'b0;
      n_res     = 2'd0;
      res0      = '0;
      res1      = '0;

      text = '0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         text[8*i +: 8] = buf_ff[i];
      end
      name_res             = '0;
      name_res.token_kind  = KIND_NAME;
      name_res.name_text   = text;
      name_res.name_length = LEN_W'(fill_ff);

      char_res            = '0;
      char_res.token_char = c;
      char_res.token_kind = punct_kind(c);

      name_char = is_letter(c) || (c >= "0" && c <= "9") || c == "_";

      if (req_ch.end_of_input) begin
         res0.token_kind  = KIND_STATUS;
         res0.status      = (err_ff == STATUS_OK && mode_ff == MODE_WANT_LF) ?
                            STATUS_BAD_CHAR : err_ff;
         res0.token_count = cnt_ff;
         n_res     = 2'd1;
         mode_in   = MODE_IDLE;
         fill_in   = '0;
         err_in    = STATUS_OK;
         cnt_clear = 1'b1;
         for (int i = 0; i < NAME_BYTES; i++) begin
            buf_in[i] = '0;
         end
      end else if (err_ff != STATUS_OK) begin
         // sticky error: bytes are dropped until end of input
      end else begin
         unique case (mode_ff)
            MODE_WANT_LF: begin
               if (c == 8'h0A) begin
                  res0            = '0;
                  res0.token_kind = KIND_EOL;
                  n_res           = 2'd1;
                  mode_in         = MODE_IDLE;
               end else begin
                  err_in = STATUS_BAD_CHAR;
               end
            end
            MODE_NAME: begin
               priority if (name_char) begin
                  if (fill_ff == FILL_W'(NAME_BYTES)) begin
                     err_in = STATUS_TOO_LONG;
                  end else begin
                     for (int i = 0; i < NAME_BYTES; i++) begin
                        if (fill_ff == FILL_W'(i)) buf_in[i] = c;
                     end
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end else if (c == "#" || c == "$") begin
                  res0                = name_res;
                  res1                = char_res;
                  res1.token_kind     = (c == "#") ? KIND_HASH : KIND_DOLLAR;
                  n_res               = 2'd2;
                  mode_in             = MODE_IDLE;
               end else if (punct_kind(c) != KIND_STATUS) begin
                  res0    = name_res;
                  res1    = char_res;
                  n_res   = 2'd2;
                  mode_in = MODE_IDLE;
               end else if (c == " " || c == 8'h09) begin
                  res0    = name_res;
                  n_res   = 2'd1;
                  mode_in = MODE_IDLE;
               end else if (c == 8'h0D) begin
                  res0    = name_res;
                  n_res   = 2'd1;
                  mode_in = MODE_WANT_LF;
               end else begin
                  err_in = STATUS_BAD_CHAR;
               end
            end
            default: begin
               priority if (is_letter(c) || c == "_") begin
                  for (int i = 0; i < NAME_BYTES; i++) begin
                     buf_in[i] = '0;
                  end
                  buf_in[0] = c;
                  fill_in   = FILL_W'(1);
                  mode_in   = MODE_NAME;
               end else if (c == 8'h0D) begin
                  mode_in = MODE_WANT_LF;
               end else if (c == " " || c == 8'h09) begin
                  // whitespace between tokens
               end else if (punct_kind(c) != KIND_STATUS) begin
                  res0  = char_res;
                  n_res = 2'd1;
               end else begin
                  err_in  = STATUS_BAD_CHAR;
                  mode_in = MODE_IDLE;
               end
            end
         endcase
      end

      if (n_res == 2'd1) res0.last = 1'b1;
      if (n_res == 2'd2) res1.last = 1'b1;
   end

   // saturating token count; the status beat itself is not counted
   always_comb begin
      cnt_sum = {1'b0, cnt_ff} + (COUNT_W + 1)'(n_res);
      if (cnt_clear) begin
         cnt_in = '0;
      end else if (cnt_sum[COUNT_W]) begin
         cnt_in = '1;
      end else begin
         cnt_in = cnt_sum[COUNT_W-1:0];
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      qcnt_in   = qcnt_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(n_res);
         qcnt_in   = qcnt_ff + QCNT_W'(n_res);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
         qcnt_in   = qcnt_in - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         fill_ff   <= '0;
         err_ff    <= STATUS_OK;
         cnt_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         qcnt_ff   <= '0;
         for (int i = 0; i < NAME_BYTES; i++) begin
            buf_ff[i] <= '0;
         end
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         qcnt_ff   <= qcnt_in;
         if (accept) begin
            mode_ff <= mode_in;
            fill_ff <= fill_in;
            err_ff  <= err_in;
            cnt_ff  <= cnt_in;
            buf_ff  <= buf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && n_res != 2'd0) queue_ff[wr_ptr_ff] <= res0;
      if (accept && n_res == 2'd2) queue_ff[wr_ptr_ff + PTR_W'(1)] <= res1;
   end

   assign rsp_ch.valid       = (qcnt_ff != '0);
   assign rsp_ch.token_kind  = queue_ff[rd_ptr_ff].token_kind;
   assign rsp_ch.token_char  = queue_ff[rd_ptr_ff].token_char;
   assign rsp_ch.name_text   = queue_ff[rd_ptr_ff].name_text;
   assign rsp_ch.name_length = queue_ff[rd_ptr_ff].name_length;
   assign rsp_ch.status      = queue_ff[rd_ptr_ff].status;
   assign rsp_ch.token_count = queue_ff[rd_ptr_ff].token_count;
   assign rsp_ch.last        = queue_ff[rd_ptr_ff].last;

endmodule

[test/tb_line_language_tokenizer_unit.sv]
// testbench of line_language_tokenizer_unit: directed and random byte streams with
// a self-contained lexer predictor and an in-order check of every result beat
// depends on ltk_pkg, ltk_req_if, ltk_rsp_if and the tokenizer rtl
module tb_line_language_tokenizer_unit;
   import ltk_pkg::*;

   localparam int NAME_CAP     = 8;
   localparam int RANDOM_BEATS = 620;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 100000;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = " ";
   localparam logic [7:0] CH_HASH   = "#";
   localparam logic [7:0] CH_DOLLAR = "$";
   localparam logic [7:0] CH_EQUALS = "=";
   localparam logic [7:0] CH_LPAREN = "(";
   localparam logic [7:0] CH_RPAREN = ")";
   localparam logic [7:0] CH_COMMA  = ",";
   localparam logic [7:0] CH_UNDER  = "_";

   typedef enum logic [1:0] {LEX_IDLE, LEX_NAME, LEX_WANT_LF} lex_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ltk_req_if req_bus ();
   ltk_rsp_if rsp_bus ();

   line_language_tokenizer_unit #(.NAME_BYTES(NAME_CAP)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   lex_state_type       lex_state;
   logic [7:0]          name_bytes [NAME_CAP];
   int                  name_fill;
   logic [STATUS_W-1:0] sticky_status;
   logic [COUNT_W-1:0]  token_total;
   rsp_type             expected_tokens [$];

   int fail_count     = 0;
   int tokens_checked = 0;
   int beats_sent     = 0;
   int streams_sent   = 0;
   int burst_left     = 0;
   bit no_gaps        = 1'b0;
   int hold_requests  = 0;
   int holds_served   = 0;
   int stall_hold_cycles = 0;
   int ready_mode     = 0;
   int mode_left      = 0;
   int cycle_count    = 0;

   function automatic bit is_letter(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'hC0 && c <= 8'hD6) || (c >= 8'hD8 && c <= 8'hF6) ||
             (c >= 8'hF8);
   endfunction

   function automatic bit is_name_byte(logic [7:0] c);
      return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER;
   endfunction

   // KIND_STATUS stands for "not punctuation"
   function automatic logic [KIND_W-1:0] punct_kind(logic [7:0] c);
      case (c)
         CH_EQUALS: return KIND_EQUALS;
         CH_LPAREN: return KIND_LPAREN;
         CH_RPAREN: return KIND_RPAREN;
         CH_COMMA:  return KIND_COMMA;
         default:   return KIND_STATUS;
      endcase
   endfunction

   function void clear_lexer();
      lex_state = LEX_IDLE;
      foreach (name_bytes[i]) name_bytes[i] = 8'h00;
      name_fill     = 0;
      sticky_status = STATUS_OK;
      token_total   = '0;
   endfunction

   function void push_token(logic [KIND_W-1:0] kind, logic [7:0] ch,
                            logic [TEXT_W-1:0] text, logic [LEN_W-1:0] len);
      rsp_type t;
      t = '0;
      t.token_kind  = kind;
      t.token_char  = ch;
      t.name_text   = text;
      t.name_length = len;
      expected_tokens.push_back(t);
      if (token_total != '1) token_total++;
   endfunction

   function void push_name();
      logic [TEXT_W-1:0] text;
      text = '0;
      for (int i = 0; i < name_fill; i++) text[8*i +: 8] = name_bytes[i];
      push_token(KIND_NAME, 8'h00, text, LEN_W'(name_fill));
   endfunction

   function void predict_beat(logic [7:0] b, logic eoi);
      int      queued_before;
      rsp_type t;
      queued_before = expected_tokens.size();
      if (eoi) begin
         if (sticky_status == STATUS_OK && lex_state == LEX_WANT_LF)
            sticky_status = STATUS_BAD_CHAR;
         t = '0;
         t.token_kind  = KIND_STATUS;
         t.status      = sticky_status;
         t.token_count = token_total;
         t.last        = 1'b1;
         expected_tokens.push_back(t);
         clear_lexer();
         return;
      end
      if (sticky_status != STATUS_OK) return;
      case (lex_state)
         LEX_WANT_LF: begin
            if (b == CH_LF) begin
               push_token(KIND_EOL, 8'h00, '0, '0);
               lex_state = LEX_IDLE;
            end else begin
               sticky_status = STATUS_BAD_CHAR;
            end
         end
         LEX_NAME: begin
            if (is_name_byte(b)) begin
               if (name_fill >= NAME_CAP) begin
                  sticky_status = STATUS_TOO_LONG;
               end else begin
                  name_bytes[name_fill] = b;
                  name_fill++;
               end
            end else if (b == CH_HASH || b == CH_DOLLAR) begin
               push_name();
               push_token(b == CH_HASH ? KIND_HASH : KIND_DOLLAR, b, '0, '0);
               lex_state = LEX_IDLE;
            end else if (punct_kind(b) != KIND_STATUS) begin
               push_name();
               push_token(punct_kind(b), b, '0, '0);
               lex_state = LEX_IDLE;
            end else if (b == CH_SPACE || b == CH_TAB) begin
               push_name();
               lex_state = LEX_IDLE;
            end else if (b == CH_CR) begin
               push_name();
               lex_state = LEX_WANT_LF;
            end else begin
               sticky_status = STATUS_BAD_CHAR;
            end
         end
         default: begin
            if (is_letter(b) || b == CH_UNDER) begin
               foreach (name_bytes[i]) name_bytes[i] = 8'h00;
               name_bytes[0] = b;
               name_fill     = 1;
               lex_state     = LEX_NAME;
            end else if (b == CH_CR) begin
               lex_state = LEX_WANT_LF;
            end else if (b == CH_SPACE || b == CH_TAB) begin
            end else if (punct_kind(b) != KIND_STATUS) begin
               push_token(punct_kind(b), b, '0, '0);
            end else begin
               sticky_status = STATUS_BAD_CHAR;
            end
         end
      endcase
      if (expected_tokens.size() > queued_before) begin
         t = expected_tokens.pop_back();
         t.last = 1'b1;
         expected_tokens.push_back(t);
      end
   endfunction

   // sender: bursts of random length, random gaps between them
   task automatic send_beat(input logic [7:0] b, input logic eoi);
      int gap;
      if (!no_gaps && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_bus.valid        <= 1'b1;
      req_bus.in_byte      <= b;
      req_bus.end_of_input <= eoi;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_beat(b, eoi);
      beats_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_beat(8'($urandom_range(0, 255)), 1'b1);
      streams_sent++;
   endtask

   function automatic logic [7:0] pick_name_byte(bit first);
      int sel;
      sel = first ? $urandom_range(0, 5) : $urandom_range(0, 6);
      case (sel)
         0:       return 8'($urandom_range(8'h41, 8'h5A));
         1:       return 8'($urandom_range(8'h61, 8'h7A));
         2:       return 8'($urandom_range(8'hC0, 8'hD6));
         3:       return 8'($urandom_range(8'hD8, 8'hF6));
         4:       return 8'($urandom_range(8'hF8, 8'hFF));
         5:       return CH_UNDER;
         default: return 8'($urandom_range(8'h30, 8'h39));
      endcase
   endfunction

   function automatic logic [7:0] pick_punct();
      case ($urandom_range(0, 3))
         0:       return CH_EQUALS;
         1:       return CH_LPAREN;
         2:       return CH_RPAREN;
         default: return CH_COMMA;
      endcase
   endfunction

   // mostly well-formed lines with random content, some noise and broken lines
   task automatic send_random_stream();
      int n, sel, len;
      logic [7:0] term;
      n = $urandom_range(2, 24);
      for (int k = 0; k < n; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            len = ($urandom_range(0, 19) == 0) ? NAME_CAP + 1 : $urandom_range(1, NAME_CAP);
            for (int j = 0; j < len; j++) send_beat(pick_name_byte(j == 0), 1'b0);
            case ($urandom_range(0, 9))
               0, 1:    term = pick_punct();
               2:       term = CH_SPACE;
               3:       term = CH_TAB;
               4:       term = CH_HASH;
               5:       term = CH_DOLLAR;
               6, 7:    term = CH_CR;
               8:       term = CH_COMMA;
               default: term = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                           : CH_EQUALS;
            endcase
            send_beat(term, 1'b0);
            if (term == CH_CR)
               send_beat(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CH_LF,
                         1'b0);
         end else if (sel < 65) begin
            send_beat(pick_punct(), 1'b0);
         end else if (sel < 75) begin
            send_beat($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
         end else if (sel < 88) begin
            send_beat(CH_CR, 1'b0);
            send_beat(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CH_LF, 1'b0);
         end else if (sel < 92) begin
            send_beat($urandom_range(0, 1) ? CH_HASH : CH_DOLLAR, 1'b0);
         end else begin
            send_beat(8'($urandom_range(0, 255)), 1'b0);
         end
      end
      send_end();
   endtask

   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
         fail_count++;
      end
   endtask

   task automatic check_token();
      rsp_type want;
      if (expected_tokens.size() == 0) begin
         $display("%0t: result beat with nothing expected, kind expected none actual %0d",
                  $time, rsp_bus.token_kind);
         fail_count++;
      end else begin
         want = expected_tokens.pop_front();
         compare_field("token_kind", 64'(want.token_kind), 64'(rsp_bus.token_kind));
         compare_field("token_char", 64'(want.token_char), 64'(rsp_bus.token_char));
         compare_field("name_text", want.name_text, rsp_bus.name_text);
         compare_field("name_length", 64'(want.name_length), 64'(rsp_bus.name_length));
         compare_field("status", 64'(want.status), 64'(rsp_bus.status));
         compare_field("token_count", 64'(want.token_count), 64'(rsp_bus.token_count));
         compare_field("last", 64'(want.last), 64'(rsp_bus.last));
      end
      tokens_checked++;
   endtask

   // receiver: checks every beat, stalls on a changing pattern or a long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_token();
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 200);
         end else begin
            mode_left--;
         end
         if (hold_requests != holds_served) begin
            holds_served++;
            stall_hold_cycles = HOLD_CYCLES;
         end
         if (stall_hold_cycles > 0) begin
            stall_hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (ready_mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= (cycle_count % 3) != 0;
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("line_language_tokenizer_unit verification failed");
         $finish;
      end
   end

   // every token kind, every name terminator but punctuation, boundary letters
   task automatic test_token_kinds();
      send_beat(CH_UNDER, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_text(" =(),x#y$z\r\nv\t");
      send_end();
   endtask

   // ninth name byte overflows the buffer, later bytes are ignored
   task automatic test_name_too_long();
      send_text("a09Z");
      send_beat(8'hC0, 1'b0);
      send_beat(8'hD6, 1'b0);
      send_beat(8'hD8, 1'b0);
      send_beat(8'hF6, 1'b0);
      send_text("z#");
      send_end();
   endtask

   task automatic test_error_cases();
      // hash outside a name
      send_beat(CH_HASH, 1'b0);
      send_end();
      // cr with end of input instead of lf
      send_beat(CH_CR, 1'b0);
      send_end();
      // zero byte inside a name
      send_text("q");
      send_beat(8'h00, 1'b0);
      send_end();
   endtask

   task automatic test_dropped_name();
      send_text("k");
      send_end();
   endtask

   task automatic test_backpressure();
      hold_requests++;
      no_gaps = 1'b1;
      for (int i = 0; i < 40; i++) begin
         send_beat(pick_name_byte(1'b1), 1'b0);
         send_beat(pick_punct(), 1'b0);
      end
      no_gaps = 1'b0;
      send_end();
   endtask

   task automatic test_random_streams();
      int start;
      start = beats_sent;
      while (beats_sent - start < RANDOM_BEATS) send_random_stream();
   endtask

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.in_byte      = 8'h00;
      req_bus.end_of_input = 1'b0;
      clear_lexer();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_token_kinds();
      test_name_too_long();
      test_error_cases();
      test_dropped_name();
      test_backpressure();
      test_random_streams();
      req_bus.valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d streams, %0d input beats, %0d result beats compared",
               streams_sent, beats_sent, tokens_checked);
      $display("covered every token kind, overflowing names, sticky errors and a long hold-off");
      if (fail_count == 0) begin
         $display("line_language_tokenizer_unit verification clean");
      end else begin
         $display("line_language_tokenizer_unit verification failed");
      end
      $finish;
   end

endmodule
